[hdl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes of the banker's safety check block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DEF_MAX_PROCS     = 16;
    localparam int DEF_MAX_RESOURCES = 8;
    localparam int DEF_AMOUNT_BITS   = 16;
    localparam int WORK_W            = 20;   // work vector wraps at 20 bits

    // input op codes
    localparam logic [2:0] OP_LOAD_MAX   = 3'd0;
    localparam logic [2:0] OP_LOAD_ALLOC = 3'd1;
    localparam logic [2:0] OP_LOAD_AVAIL = 3'd2;
    localparam logic [2:0] OP_LOAD_REQ   = 3'd3;
    localparam logic [2:0] OP_RUN        = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_SEQ     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNSAFE    = 3'd1;
    localparam logic [2:0] ST_OVER_AV   = 3'd2;
    localparam logic [2:0] ST_TABLE_ERR = 3'd3;
    localparam logic [2:0] ST_OVER_NEED = 3'd4;

    // register indexes
    localparam logic REG_PROCS = 1'b0;
    localparam logic REG_RES   = 1'b1;

    typedef struct packed {
        logic max_we;
        logic alloc_we;
    } t_tbl_we;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_LD   = 17'h00002,
        S_RCHK = 17'h00004,
        S_NRD  = 17'h00008,
        S_NCMP = 17'h00010,
        S_GRD  = 17'h00020,
        S_GWR  = 17'h00040,
        S_CAND = 17'h00080,
        S_FRD  = 17'h00100,
        S_FCMP = 17'h00200,
        S_ARD  = 17'h00400,
        S_AADD = 17'h00800,
        S_BRD  = 17'h01000,
        S_BWR  = 17'h02000,
        S_ORD  = 17'h04000,
        S_OEM  = 17'h08000,
        S_VERD = 17'h10000
    } t_state;

endpackage

[hdl/bankers_safety_check.sv]
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm request check with a cyclic safety scan.
// ----------------------------------------------------------------------------
// Load transfers (ops 0..3) write one entry of the max or allocation table,
// the available vector or the request vector; each returns one acknowledge.
// A run transfer (op 4) checks the request of the named process against
// available, then against that process's need (read from the table memory
// resource by resource), grants it resource by resource, and scans for a
// safe order. The scan is bound by the single read port of the table memory:
// each candidate's need is read and compared resource by resource, and each
// chosen process's allocation is read again for the work update. An unsafe
// result rolls the grant back resource by resource; a safe one streams out
// the order, one entry at a time, then the verdict. No input is taken while
// a transfer is being worked on. After reset both tables are cleared to
// zero, one entry per cycle, so no input transfer is taken until all
// 2^(PW+RW) entries (128 with the default sizes) are cleared.
// ----------------------------------------------------------------------------
module bankers_safety_check #(
    parameter int MAX_PROCS     = bsc_pkg::DEF_MAX_PROCS,
    parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES,
    parameter int AMOUNT_BITS   = bsc_pkg::DEF_AMOUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // process_index[3:0], resource_index[6:4],
                                     // amount[22:7], zero[23]
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // process_out[3:0], status[6:4], zero[7]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast,
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import bsc_pkg::*;

    localparam int PW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int ADW  = PW + RW;
    localparam int PCW  = $clog2(MAX_PROCS + 1);
    localparam int RCW  = $clog2(MAX_RESOURCES + 1);
    localparam int AW   = AMOUNT_BITS;
    localparam int CW   = (AW > WORK_W) ? AW : WORK_W;

    // ---- input fields ----
    logic [3:0] in_p;
    logic [2:0] in_r;
    logic [AW-1:0] in_amt;
    assign in_p   = i_s_tdata[3:0];
    assign in_r   = i_s_tdata[6:4];
    assign in_amt = AW'(i_s_tdata[22:7]);

    // ---- registers ----
    t_state r_state, n_state;
    logic [PCW-1:0] r_nproc;
    logic [RCW-1:0] r_nres;
    logic           r_err;          // sticky table error
    logic [2:0]     r_op;
    logic [3:0]     r_p;
    logic [2:0]     r_r;
    logic [AW-1:0]  r_amt;
    logic           r_ldok;         // max or alloc load, index in range
    logic [AW-1:0]  r_avail [MAX_RESOURCES];
    logic [AW-1:0]  r_req   [MAX_RESOURCES];
    logic [CW-1:0]  r_work  [MAX_RESOURCES];
    logic [MAX_PROCS-1:0] r_done;
    logic [PW-1:0]  order_mem [MAX_PROCS];
    logic [PW-1:0]  r_orderq;
    logic [RCW-1:0] r_i;            // resource counter
    logic [PW-1:0]  r_j;            // scan candidate
    logic [PCW-1:0] r_off;          // candidates tried in this pass
    logic [PCW-1:0] r_picked;
    logic [PCW-1:0] r_e;            // order emit counter
    logic [2:0]     r_vstat;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_okind;
    logic [3:0]     r_oproc;
    logic [2:0]     r_ostat;
    logic           r_olast;
    logic [ADW:0]   r_clr;          // clearing pass address, top bit = done

    // ---- table memory ----
    logic [ADW-1:0] rd_addr, wr_addr, addr_p, addr_j, addr_ld;
    logic [AW-1:0]  wdata, max_q, alloc_q, need;
    t_tbl_we        tbl_we;
    logic [RW-1:0]  ri;
    logic           clr_busy, in_acc;

    assign ri       = r_i[RW-1:0];
    assign addr_p   = {PW'(r_p), ri};
    assign addr_j   = {r_j, ri};
    assign addr_ld  = {PW'(r_p), RW'(r_r)};
    assign need     = max_q - alloc_q;
    assign clr_busy = !r_clr[ADW];
    assign in_acc   = i_s_tvalid && o_s_tready;

    bsc_tables #(
        .ADDR_W (ADW),
        .DATA_W (AW)
    ) u_tables (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wdata   (wdata),
        .i_we      (tbl_we),
        .o_max_q   (max_q),
        .o_alloc_q (alloc_q)
    );

    // result slot free for a new transfer this cycle
    logic slot_free;
    assign slot_free = !r_ovalid || i_m_tready;

    // load error check against the other table's current entry
    logic ld_err;
    always_comb begin
        ld_err = 1'b0;
        if (r_ldok) begin
            if (r_op == OP_LOAD_MAX) begin
                ld_err = alloc_q > r_amt;
            end else begin
                ld_err = r_amt > max_q;
            end
        end
    end

    // request above available, over the resources in use
    logic over_av;
    always_comb begin
        over_av = 1'b0;
        for (int k = 0; k < MAX_RESOURCES; k++) begin
            if (RCW'(k) < r_nres && r_req[k] > r_avail[k]) begin
                over_av = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:                rd_addr = {PW'(in_p), RW'(in_r)};
            S_LD:                  rd_addr = addr_ld;
            S_FRD, S_FCMP,
            S_ARD, S_AADD:         rd_addr = addr_j;
            default:               rd_addr = addr_p;
        endcase
    end

    always_comb begin
        tbl_we  = '0;
        wr_addr = addr_p;
        wdata   = alloc_q + r_req[ri];
        if (clr_busy) begin
            // clearing pass after reset: both tables, one entry per cycle
            tbl_we.max_we   = 1'b1;
            tbl_we.alloc_we = 1'b1;
            wr_addr         = r_clr[ADW-1:0];
            wdata           = '0;
        end
        case (r_state)
            S_LD: begin
                wr_addr = addr_ld;
                wdata   = r_amt;
                if (slot_free && r_ldok) begin
                    tbl_we.max_we   = (r_op == OP_LOAD_MAX);
                    tbl_we.alloc_we = (r_op == OP_LOAD_ALLOC);
                end
            end
            S_GWR: begin
                tbl_we.alloc_we = 1'b1;
            end
            S_BWR: begin
                wdata           = alloc_q - r_req[ri];
                tbl_we.alloc_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---- counters and wrap helpers ----
    logic i_last, j_wrap, e_last;
    logic [CW:0] work_sum;
    assign i_last   = (r_i + RCW'(1)) == r_nres;
    assign j_wrap   = (PCW'(r_j) + PCW'(1)) == r_nproc;
    assign e_last   = (r_e + PCW'(1)) == r_picked;
    assign work_sum = (CW + 1)'(r_work[ri]) + (CW + 1)'(alloc_q);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == OP_RUN) begin
                        n_state = S_RCHK;
                    end else if (i_s_tuser == OP_LOAD_MAX || i_s_tuser == OP_LOAD_ALLOC ||
                                 i_s_tuser == OP_LOAD_AVAIL || i_s_tuser == OP_LOAD_REQ) begin
                        n_state = S_LD;
                    end
                end
            end
            S_LD:   if (slot_free) n_state = S_IDLE;
            S_RCHK: begin
                if (r_err || PCW'(r_p) >= r_nproc || 32'(r_p) >= MAX_PROCS || over_av) begin
                    n_state = S_VERD;
                end else begin
                    n_state = S_NRD;
                end
            end
            S_NRD:  n_state = S_NCMP;
            S_NCMP: begin
                if (r_req[ri] > need) n_state = S_VERD;
                else if (i_last)      n_state = S_GRD;
                else                  n_state = S_NRD;
            end
            S_GRD:  n_state = S_GWR;
            S_GWR:  n_state = i_last ? S_CAND : S_GRD;
            S_CAND: begin
                if (r_off == r_nproc) begin
                    n_state = (r_picked == r_nproc) ? S_ORD : S_BRD;
                end else if (!r_done[r_j]) begin
                    n_state = S_FRD;
                end
            end
            S_FRD:  n_state = S_FCMP;
            S_FCMP: begin
                if (CW'(need) > r_work[ri]) n_state = S_CAND;
                else if (i_last)            n_state = S_ARD;
                else                        n_state = S_FRD;
            end
            S_ARD:  n_state = S_AADD;
            S_AADD: n_state = i_last ? S_CAND : S_ARD;
            S_BRD:  n_state = S_BWR;
            S_BWR:  n_state = i_last ? S_VERD : S_BRD;
            S_ORD:  n_state = S_OEM;
            S_OEM:  if (slot_free) n_state = e_last ? S_VERD : S_ORD;
            S_VERD: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // result valid: set when a result is loaded, cleared once taken
    always_comb begin
        n_ovalid = r_ovalid && !i_m_tready;
        if (slot_free && (r_state == S_LD || r_state == S_OEM || r_state == S_VERD)) begin
            n_ovalid = 1'b1;
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
            r_done   <= '0;
            r_clr    <= '0;
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_work[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (clr_busy) begin
                r_clr <= r_clr + (ADW + 1)'(1);
            end
            case (r_state)
                S_IDLE: begin
                    r_op   <= i_s_tuser;
                    r_p    <= in_p;
                    r_r    <= in_r;
                    r_amt  <= in_amt;
                    r_ldok <= (32'(in_p) < MAX_PROCS) && (32'(in_r) < MAX_RESOURCES)
                              && (i_s_tuser == OP_LOAD_MAX || i_s_tuser == OP_LOAD_ALLOC);
                    if (in_acc && 32'(in_r) < MAX_RESOURCES) begin
                        if (i_s_tuser == OP_LOAD_AVAIL) r_avail[RW'(in_r)] <= in_amt;
                        if (i_s_tuser == OP_LOAD_REQ)   r_req[RW'(in_r)]   <= in_amt;
                    end
                end
                S_LD: begin
                    if (slot_free) begin
                        r_err    <= r_err || ld_err;
                        r_okind  <= KIND_ACK;
                        r_oproc  <= '0;
                        r_ostat  <= (r_err || ld_err) ? ST_TABLE_ERR : ST_OK;
                        r_olast  <= 1'b1;
                    end
                end
                S_RCHK: begin
                    r_i     <= '0;
                    r_vstat <= (r_err || PCW'(r_p) >= r_nproc || 32'(r_p) >= MAX_PROCS)
                               ? ST_TABLE_ERR : ST_OVER_AV;
                end
                S_NCMP: begin
                    r_vstat <= ST_OVER_NEED;
                    r_i     <= i_last ? '0 : r_i + RCW'(1);
                    if (i_last) begin
                        r_done   <= '0;
                        r_picked <= '0;
                        r_j      <= '0;
                        r_off    <= '0;
                    end
                end
                S_GWR: begin
                    r_avail[ri] <= r_avail[ri] - r_req[ri];
                    r_work[ri]  <= CW'(r_avail[ri] - r_req[ri]);
                    r_i         <= i_last ? '0 : r_i + RCW'(1);
                end
                S_CAND: begin
                    r_i <= '0;
                    if (r_off == r_nproc) begin
                        r_e     <= '0;
                        r_vstat <= (r_picked == r_nproc) ? ST_OK : ST_UNSAFE;
                    end else if (r_done[r_j]) begin
                        r_off <= r_off + PCW'(1);
                        r_j   <= j_wrap ? '0 : r_j + PW'(1);
                    end
                end
                S_FCMP: begin
                    if (CW'(need) > r_work[ri]) begin
                        // candidate does not fit: move on
                        r_off <= r_off + PCW'(1);
                        r_j   <= j_wrap ? '0 : r_j + PW'(1);
                    end else begin
                        r_i <= i_last ? '0 : r_i + RCW'(1);
                    end
                end
                S_AADD: begin
                    r_work[ri] <= CW'(work_sum[WORK_W-1:0]);
                    r_i        <= i_last ? '0 : r_i + RCW'(1);
                    if (i_last) begin
                        r_done[r_j] <= 1'b1;
                        r_picked    <= r_picked + PCW'(1);
                        r_off       <= '0;
                    end
                end
                S_BWR: begin
                    r_avail[ri] <= r_avail[ri] + r_req[ri];
                    r_i         <= i_last ? '0 : r_i + RCW'(1);
                end
                S_OEM: begin
                    if (slot_free) begin
                        r_okind  <= KIND_SEQ;
                        r_oproc  <= 4'(r_orderq);
                        r_ostat  <= ST_OK;
                        r_olast  <= 1'b0;
                        r_e      <= r_e + PCW'(1);
                    end
                end
                S_VERD: begin
                    if (slot_free) begin
                        r_okind  <= KIND_VERDICT;
                        r_oproc  <= '0;
                        r_ostat  <= r_vstat;
                        r_olast  <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // order memory: written on each pick, read back while streaming out
    always_ff @(posedge i_clk) begin
        if (r_state == S_AADD && i_last) begin
            order_mem[r_picked[PW-1:0]] <= r_j;
        end
        r_orderq <= order_mem[r_e[PW-1:0]];
    end

    // ---- configuration ----
    function automatic logic [PCW-1:0] clamp_procs(input logic [4:0] v);
        logic [PCW-1:0] res;
        if (v == 5'd0)                  res = PCW'(1);
        else if (32'(v) > MAX_PROCS)    res = PCW'(MAX_PROCS);
        else                            res = PCW'(v);
        return res;
    endfunction

    function automatic logic [RCW-1:0] clamp_res(input logic [3:0] v);
        logic [RCW-1:0] res;
        if (v == 4'd0)                  res = RCW'(1);
        else if (32'(v) > MAX_RESOURCES) res = RCW'(MAX_RESOURCES);
        else                            res = RCW'(v);
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nproc <= PCW'(1);
            r_nres  <= RCW'(1);
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2] == REG_PROCS) r_nproc <= clamp_procs(i_pwdata[4:0]);
            else                         r_nres  <= clamp_res(i_pwdata[3:0]);
        end
    end

    assign o_prdata = (i_paddr[2] == REG_RES) ? 32'(r_nres) : 32'(r_nproc);
    assign o_pready = 1'b1;

    // ---- ports ----
    assign o_s_tready = (r_state == S_IDLE) && !clr_busy;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_ostat, r_oproc};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

endmodule

[hdl/bsc_tables.sv]
// ----------------------------------------------------------------------------
// bsc_tables
// Maximum and allocation tables: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsc_tables #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic                 i_clk,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [DATA_W-1:0]    i_wdata,
    input  bsc_pkg::t_tbl_we     i_we,
    output logic [DATA_W-1:0]    o_max_q,
    output logic [DATA_W-1:0]    o_alloc_q
);
    import bsc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] max_mem   [DEPTH];
    logic [DATA_W-1:0] alloc_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.max_we) begin
            max_mem[i_wr_addr] <= i_wdata;
        end
        if (i_we.alloc_we) begin
            alloc_mem[i_wr_addr] <= i_wdata;
        end
        o_max_q   <= max_mem[i_rd_addr];
        o_alloc_q <= alloc_mem[i_rd_addr];
    end

endmodule

[hdl/bsc_checker.sv]
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the banker's safety check block, bound to the top.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [2:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);
    import bsc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // sequence entries never close a run; acks and verdicts always do
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser != KIND_SEQ)))
        else $error("tlast does not match result kind");

    // only sequence entries carry a process; they carry status ok
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == KIND_SEQ) ? (o_m_tdata[6:4] == ST_OK)
                                               : (o_m_tdata[3:0] == 4'd0))
        else $error("result fields inconsistent with kind");

    // a valid op blocks the input until its work is done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_LOAD_MAX ||
        i_s_tuser == OP_LOAD_ALLOC || i_s_tuser == OP_LOAD_AVAIL ||
        i_s_tuser == OP_LOAD_REQ || i_s_tuser == OP_RUN) |=> !o_s_tready)
        else $error("input taken while busy");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (.*);
